### rtl/core/nps_pkg.sv
// shared types and field widths for the non-preemptive priority scheduler
// no dependencies; imported by the pick unit, the top level and the checker
package nps_pkg;

    localparam int ArrW   = 8;
    localparam int BurW   = 8;
    localparam int PriW   = 4;
    localparam int TimeW  = 16;
    localparam int IdxW   = 5;
    localparam int JobW   = ArrW + BurW + PriW;
    localparam int SDataW = 24;
    localparam int MDataW = 56;

    // one stored job, arrival in the lowest bits
    typedef struct packed {
        logic [PriW-1:0] prio;
        logic [BurW-1:0] burst;
        logic [ArrW-1:0] arr;
    } t_job;

    // scan control from the sequencer to the pick unit
    typedef struct packed {
        logic clr;
        logic vld;
    } t_scan_ctl;

    // best candidate found so far
    typedef struct packed {
        logic found;
        t_job job;
    } t_cand;

endpackage

### rtl/core/nps_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies; used for the job store
module nps_ram #(
    parameter int W = 8,
    parameter int D = 32
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/nps_pick.sv
// pick unit: keeps the best arrived job and the earliest unfinished job
// over one scan of the job store; depends on nps_pkg
module nps_pick #(
    parameter int AW = 5
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  nps_pkg::t_scan_ctl       i_ctl,
    input  nps_pkg::t_job            i_job,
    input  logic [AW-1:0]            i_idx,
    input  logic [nps_pkg::TimeW-1:0] i_time,
    output nps_pkg::t_cand           o_rdy_cand,
    output logic [AW-1:0]            o_rdy_idx,
    output nps_pkg::t_cand           o_early_cand,
    output logic [AW-1:0]            o_early_idx
);
    import nps_pkg::*;

    logic          r_rdy_found;
    t_job          r_rdy_job;
    logic [AW-1:0] r_rdy_idx;
    logic          r_early_found;
    t_job          r_early_job;
    logic [AW-1:0] r_early_idx;
    logic          w_arrived;
    logic          w_take_rdy;
    logic          w_take_early;

    // arrived job: lower priority value, then earlier arrival, then load order
    assign w_arrived  = TimeW'(i_job.arr) <= i_time;
    assign w_take_rdy = i_ctl.vld && w_arrived &&
                        (!r_rdy_found || (i_job.prio < r_rdy_job.prio) ||
                         ((i_job.prio == r_rdy_job.prio) && (i_job.arr < r_rdy_job.arr)));

    // fallback: earliest arrival, then priority, then load order
    assign w_take_early = i_ctl.vld &&
                          (!r_early_found || (i_job.arr < r_early_job.arr) ||
                           ((i_job.arr == r_early_job.arr) && (i_job.prio < r_early_job.prio)));

    // found flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy_found   <= 1'b0;
            r_early_found <= 1'b0;
        end else if (i_ctl.clr) begin
            r_rdy_found   <= 1'b0;
            r_early_found <= 1'b0;
        end else begin
            if (w_take_rdy) begin
                r_rdy_found <= 1'b1;
            end
            if (w_take_early) begin
                r_early_found <= 1'b1;
            end
        end
    end

    // candidate payload
    always_ff @(posedge i_clk) begin
        if (w_take_rdy) begin
            r_rdy_job <= i_job;
            r_rdy_idx <= i_idx;
        end
        if (w_take_early) begin
            r_early_job <= i_job;
            r_early_idx <= i_idx;
        end
    end

    assign o_rdy_cand   = '{found: r_rdy_found, job: r_rdy_job};
    assign o_rdy_idx    = r_rdy_idx;
    assign o_early_cand = '{found: r_early_found, job: r_early_job};
    assign o_early_idx  = r_early_idx;

endmodule

### rtl/core/nonpreemptive_priority_scheduler.sv
// top level of the non-preemptive priority scheduler: load sequencer,
// dispatch sequencer and time arithmetic; depends on nps_pkg, nps_ram, nps_pick
//
//   channel  direction  tdata fields (low bit up)                     tuser           tlast
//   s        in         arrival_time, burst_time, job_priority        -               load_last
//   m        out        job_index, completion_time, turnaround, wait  table_overflow  result_last
//
// loading accepts one item per cycle; the last item starts the schedule
// each dispatch scans the stored jobs through the single read port, then picks a job,
// works out its turnaround and waiting time and waits for the result to be taken
// o_s_tready is low from the last item until the last result is taken
// a stalled result holds; reset is synchronous, active low, and needs no clearing pass
module nonpreemptive_priority_scheduler #(
    parameter int MAX_PROCS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [nps_pkg::SDataW-1:0]  i_s_tdata,  // arrival_time, burst_time, job_priority
    input  logic                        i_s_tlast,  // load_last
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [nps_pkg::MDataW-1:0]  o_m_tdata,  // job_index, completion, turnaround, waiting
    output logic                        o_m_tuser,  // table_overflow
    output logic                        o_m_tlast   // result_last
);
    import nps_pkg::*;

    localparam int AW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int EW = (AW > IdxW) ? AW : IdxW;

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_PICK = 3'd2;
    localparam logic [2:0] ST_TAT  = 3'd3;
    localparam logic [2:0] ST_WT   = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]           r_state, n_state;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_ovf, n_ovf;
    logic [MAX_PROCS-1:0] r_done, n_done;
    logic [CW-1:0]        r_k, n_k;
    logic [CW-1:0]        r_addr, n_addr;
    logic                 r_pv, n_pv;
    logic [AW-1:0]        r_rd_idx, n_rd_idx;
    logic [TimeW-1:0]     r_time, n_time;
    logic [AW-1:0]        r_sel_idx, n_sel_idx;
    logic [ArrW-1:0]      r_sel_arr, n_sel_arr;
    logic [BurW-1:0]      r_sel_bur, n_sel_bur;
    logic [TimeW-1:0]     r_tat, n_tat;
    logic [TimeW-1:0]     r_wt, n_wt;

    logic                 w_s_acc;
    logic                 w_we;
    t_job                 w_wjob;
    logic [JobW-1:0]      w_rdata;
    t_job                 w_rjob;
    t_scan_ctl            w_ctl;
    t_cand                w_rdy_cand;
    logic [AW-1:0]        w_rdy_idx;
    t_cand                w_early_cand;
    logic [AW-1:0]        w_early_idx;
    t_job                 w_pick_job;
    logic [TimeW-1:0]     w_base;
    logic                 w_last_res;
    logic [EW-1:0]        w_idx_ext;

    assign w_s_acc = i_s_tvalid && o_s_tready;
    assign w_wjob  = t_job'(i_s_tdata[JobW-1:0]);
    assign w_rjob  = t_job'(w_rdata);

    // job store
    nps_ram #(
        .W(JobW),
        .D(MAX_PROCS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (w_wjob),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // shared compare unit for the scan
    nps_pick #(
        .AW(AW)
    ) u_pick (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_job        (w_rjob),
        .i_idx        (r_rd_idx),
        .i_time       (r_time),
        .o_rdy_cand   (w_rdy_cand),
        .o_rdy_idx    (w_rdy_idx),
        .o_early_cand (w_early_cand),
        .o_early_idx  (w_early_idx)
    );

    // dispatch choice: best arrived job, else jump to the earliest one
    assign w_pick_job = w_rdy_cand.found ? w_rdy_cand.job : w_early_cand.job;
    assign w_base     = w_rdy_cand.found ? r_time : TimeW'(w_early_cand.job.arr);
    assign w_last_res = (r_k == CW'(r_cnt - 1'b1));

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_ovf     = r_ovf;
        n_done    = r_done;
        n_k       = r_k;
        n_addr    = r_addr;
        n_pv      = 1'b0;
        n_rd_idx  = r_rd_idx;
        n_time    = r_time;
        n_sel_idx = r_sel_idx;
        n_sel_arr = r_sel_arr;
        n_sel_bur = r_sel_bur;
        n_tat     = r_tat;
        n_wt      = r_wt;
        w_we      = 1'b0;
        w_ctl.clr = 1'b0;
        w_ctl.vld = r_pv && !r_done[r_rd_idx];
        unique case (r_state)
            ST_LOAD: begin
                if (w_s_acc) begin
                    if (r_cnt < CW'(MAX_PROCS)) begin
                        w_we  = 1'b1;
                        n_cnt = r_cnt + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_s_tlast) begin
                        n_state   = ST_SCAN;
                        n_done    = '0;
                        n_time    = '0;
                        n_k       = '0;
                        n_addr    = '0;
                        w_ctl.clr = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (r_addr < r_cnt) begin
                    n_addr   = r_addr + 1'b1;
                    n_pv     = 1'b1;
                    n_rd_idx = r_addr[AW-1:0];
                end else if (!r_pv) begin
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                n_sel_idx         = w_rdy_cand.found ? w_rdy_idx : w_early_idx;
                n_sel_arr         = w_pick_job.arr;
                n_sel_bur         = w_pick_job.burst;
                n_time            = w_base + TimeW'(w_pick_job.burst);
                n_done[n_sel_idx] = 1'b1;
                n_state           = ST_TAT;
            end
            ST_TAT: begin
                n_tat   = r_time - TimeW'(r_sel_arr);
                n_state = ST_WT;
            end
            ST_WT: begin
                n_wt    = r_tat - TimeW'(r_sel_bur);
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_m_tready) begin
                    if (w_last_res) begin
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                        n_state = ST_LOAD;
                    end else begin
                        n_k       = r_k + 1'b1;
                        n_addr    = '0;
                        w_ctl.clr = 1'b1;
                        n_state   = ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_done  <= '0;
            r_k     <= '0;
            r_addr  <= '0;
            r_pv    <= 1'b0;
            r_time  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_done  <= n_done;
            r_k     <= n_k;
            r_addr  <= n_addr;
            r_pv    <= n_pv;
            r_time  <= n_time;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx  <= n_rd_idx;
        r_sel_idx <= n_sel_idx;
        r_sel_arr <= n_sel_arr;
        r_sel_bur <= n_sel_bur;
        r_tat     <= n_tat;
        r_wt      <= n_wt;
    end

    // result item
    assign w_idx_ext  = EW'(r_sel_idx);
    assign o_s_tready = (r_state == ST_LOAD);
    assign o_m_tvalid = (r_state == ST_OUT);
    assign o_m_tdata  = {3'b000, r_wt, r_tat, r_time, w_idx_ext[IdxW-1:0]};
    assign o_m_tuser  = r_ovf;
    assign o_m_tlast  = w_last_res;

endmodule

### rtl/core/nps_checker.sv
// port-level checker for the non-preemptive priority scheduler, bound to the top
// depends on nps_pkg and nonpreemptive_priority_scheduler
module nps_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_s_tvalid,
    input logic                       o_s_tready,
    input logic [nps_pkg::SDataW-1:0] i_s_tdata,
    input logic                       i_s_tlast,
    input logic                       o_m_tvalid,
    input logic                       i_m_tready,
    input logic [nps_pkg::MDataW-1:0] o_m_tdata,
    input logic                       o_m_tuser,
    input logic                       o_m_tlast
);
    import nps_pkg::*;

    // loading and result delivery never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while a result is shown");

    // a non-final item keeps the block loading
    a_keep_loading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !i_s_tlast) |=> o_s_tready)
        else $error("ready dropped after a non-final item");

    // the final item starts the schedule
    a_start_sched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> !o_s_tready)
        else $error("ready stayed high after the final item");

    // the last result returns the block to loading
    a_back_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> o_s_tready)
        else $error("not ready after the last result");

    // a stalled result holds
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
        (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast)))
        else $error("stalled result changed");

endmodule

bind nonpreemptive_priority_scheduler nps_checker u_nps_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

### sim/testbench.sv
// self-checking testbench for the non-preemptive priority scheduler
// drives job sets over the input stream and checks every dispatch result
// depends on nps_pkg and the nonpreemptive_priority_scheduler rtl
module testbench;

    import nps_pkg::*;

    localparam int          MAX_JOBS    = 32;
    localparam int          ITEMS       = 410;
    localparam int          LONG_HOLD   = 3000;
    localparam int          DRAIN       = 100;
    localparam int unsigned CYCLE_LIMIT = 500000;

    // one expected dispatch, fields as they leave the block
    typedef struct packed {
        logic [IdxW-1:0]  idx;
        logic [TimeW-1:0] comp;
        logic [TimeW-1:0] tat;
        logic [TimeW-1:0] wt;
        logic             ovf;
        logic             last;
    } t_dispatch;

    // mirror of the job table plus the queue of dispatches still owed
    class dispatch_board;
        t_job        jobs[MAX_JOBS];
        int unsigned job_count;
        bit          dropped;
        t_dispatch   dispatch_q[$];
        int unsigned faults;

        function new();
            job_count = 0;
            dropped   = 0;
            faults    = 0;
        endfunction

        function int unsigned pending();
            return dispatch_q.size();
        endfunction

        // x goes first: lower priority value, then earlier arrival, then load order
        function bit ahead(int unsigned x, int unsigned y);
            if (jobs[x].prio != jobs[y].prio)
                return jobs[x].prio < jobs[y].prio;
            if (jobs[x].arr != jobs[y].arr)
                return jobs[x].arr < jobs[y].arr;
            return x < y;
        endfunction

        // schedule the stored set and queue its results in dispatch order
        function void dispatch_set();
            bit          done[MAX_JOBS];
            int unsigned now;
            int unsigned nxt;
            int unsigned pick;
            t_dispatch   res;
            now = 'hFFFF;
            for (int i = 0; i < job_count; i++) begin
                done[i] = 1'b0;
                if (jobs[i].arr < now)
                    now = jobs[i].arr;
            end
            for (int k = 0; k < job_count; k++) begin
                nxt  = 'hFFFF;
                pick = job_count;
                for (int i = 0; i < job_count; i++) begin
                    if (!done[i] && jobs[i].arr < nxt)
                        nxt = jobs[i].arr;
                end
                // nothing ready yet: jump to the next arrival
                if (nxt > now)
                    now = nxt;
                for (int i = 0; i < job_count; i++) begin
                    if (!done[i] && jobs[i].arr <= now &&
                        (pick == job_count || ahead(i, pick)))
                        pick = i;
                end
                done[pick] = 1'b1;
                now      = (now + jobs[pick].burst) & 'hFFFF;
                res.idx  = IdxW'(pick);
                res.comp = TimeW'(now);
                res.tat  = res.comp - TimeW'(jobs[pick].arr);
                res.wt   = res.tat - TimeW'(jobs[pick].burst);
                res.ovf  = dropped;
                res.last = (k + 1 == job_count);
                dispatch_q.push_back(res);
            end
        endfunction

        // accepted input item
        function void note_job(t_job job, bit last);
            if (job_count < MAX_JOBS) begin
                jobs[job_count] = job;
                job_count++;
            end else begin
                dropped = 1'b1;
            end
            if (last) begin
                dispatch_set();
                job_count = 0;
                dropped   = 1'b0;
            end
        endfunction

        function void compare(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
                faults++;
            end
        endfunction

        // accepted result item against the oldest expectation
        function void check_dispatch(logic [MDataW-1:0] data, logic ovf, logic last);
            t_dispatch got;
            t_dispatch want;
            got.idx  = data[4:0];
            got.comp = data[20:5];
            got.tat  = data[36:21];
            got.wt   = data[52:37];
            got.ovf  = ovf;
            got.last = last;
            if (dispatch_q.size() == 0) begin
                $display("%0t: unexpected result, expected none actual job_index %0d",
                         $time, got.idx);
                faults++;
                return;
            end
            want = dispatch_q.pop_front();
            compare("job_index", want.idx, got.idx);
            compare("completion_time", want.comp, got.comp);
            compare("turnaround_time", want.tat, got.tat);
            compare("waiting_time", want.wt, got.wt);
            compare("table_overflow", want.ovf, got.ovf);
            compare("result_last", want.last, got.last);
        endfunction
    endclass

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [SDataW-1:0]  i_s_tdata  = '0;
    logic               i_s_tlast  = 1'b0;
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [MDataW-1:0]  o_m_tdata;
    logic               o_m_tuser;
    logic               o_m_tlast;

    dispatch_board sb = new();

    int unsigned cycles     = 0;
    int          items_sent = 0;
    int          hold_req   = 0;
    bit          send_calm  = 1'b0;

    nonpreemptive_priority_scheduler #(
        .MAX_PROCS (MAX_JOBS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // arrival_time, burst_time, job_priority
        .i_s_tlast  (i_s_tlast),   // load_last
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // job_index, completion, turnaround, waiting
        .o_m_tuser  (o_m_tuser),   // table_overflow
        .o_m_tlast  (o_m_tlast)    // result_last
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // monitors on both handshakes
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready)
            sb.note_job(t_job'(i_s_tdata[JobW-1:0]), i_s_tlast);
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_dispatch(o_m_tdata, o_m_tuser, o_m_tlast);
    end

    // offer one job and hold it until taken
    task automatic send_item(input logic [ArrW-1:0] arr, input logic [BurW-1:0] bur,
                             input logic [PriW-1:0] pri, input bit last);
        int   gap;
        t_job job;
        gap = send_calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        job.arr   = arr;
        job.burst = bur;
        job.prio  = pri;
        i_s_tdata  <= {{(SDataW-JobW){1'b0}}, job};
        i_s_tlast  <= last;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
    endtask

    // result side: random back-pressure in stretches, plus one long hold on request
    initial begin : receiver
        int gap;
        int stretch;
        bit calm;
        stretch = 0;
        calm    = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (stretch == 0) begin
                stretch = $urandom_range(5, 30);
                calm    = ($urandom_range(0, 2) == 0);
            end
            stretch--;
            gap = calm ? 0 : $urandom_range(0, 10);
            if (hold_req != 0) begin
                gap      = hold_req;
                hold_req = 0;
            end
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    // stimulus
    initial begin : stimulus
        int          set_no;
        int          size;
        int unsigned arr_hi;
        int unsigned bur_hi;
        logic [ArrW-1:0] a;
        logic [BurW-1:0] b;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single jobs at the field extremes
        send_item(8'd255, 8'd255, 4'd15, 1'b1);
        send_item(8'd0, 8'd0, 4'd0, 1'b1);
        // idle gaps force clock jumps; equal priority and arrival go by load order
        send_item(8'd10, 8'd5, 4'd3, 1'b0);
        send_item(8'd10, 8'd5, 4'd3, 1'b0);
        send_item(8'd4, 8'd2, 4'd3, 1'b0);
        send_item(8'd0, 8'd1, 4'd7, 1'b1);
        // equal priority, earlier arrival wins
        send_item(8'd2, 8'd3, 4'd5, 1'b0);
        send_item(8'd1, 8'd3, 4'd5, 1'b0);
        send_item(8'd0, 8'd8, 4'd0, 1'b1);
        // priority beats arrival once both are ready
        send_item(8'd0, 8'd20, 4'd9, 1'b0);
        send_item(8'd1, 8'd4, 4'd2, 1'b0);
        send_item(8'd2, 8'd4, 4'd1, 1'b0);
        send_item(8'd3, 8'd4, 4'd15, 1'b1);
        // zero bursts and late arrivals
        send_item(8'd255, 8'd0, 4'd0, 1'b0);
        send_item(8'd0, 8'd0, 4'd15, 1'b0);
        send_item(8'd128, 8'd255, 4'd8, 1'b1);
        send_item(8'd255, 8'd255, 4'd0, 1'b0);
        send_item(8'd255, 8'd255, 4'd0, 1'b1);

        // random sets, mostly small, a full table and a few overflowing ones
        set_no = 0;
        while (items_sent < ITEMS) begin
            if (set_no == 3)
                size = MAX_JOBS;
            else if (set_no == 7 || set_no == 14 || set_no == 20)
                size = MAX_JOBS + 1 + $urandom_range(0, 3);
            else if ($urandom_range(0, 4) == 0)
                size = $urandom_range(7, 20);
            else
                size = $urandom_range(1, 6);
            case ($urandom_range(0, 2))
                0:       arr_hi = 15;
                1:       arr_hi = 63;
                default: arr_hi = 255;
            endcase
            case ($urandom_range(0, 2))
                0:       bur_hi = 7;
                1:       bur_hi = 63;
                default: bur_hi = 255;
            endcase
            send_calm = ($urandom_range(0, 3) == 0);
            // long receiver stall while this set and the next are offered
            if (set_no == 5)
                hold_req = LONG_HOLD;
            // let the block drain completely before this set
            if (set_no == 10) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
                while (sb.pending() != 0) @(posedge i_clk);
            end
            for (int j = 0; j < size; j++) begin
                a = ArrW'($urandom_range(0, arr_hi));
                b = BurW'($urandom_range(0, bur_hi));
                if ($urandom_range(0, 15) == 0)
                    a = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                if ($urandom_range(0, 15) == 0)
                    b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                send_item(a, b, PriW'($urandom_range(0, 15)), j == size - 1);
            end
            set_no++;
        end
        i_s_tvalid <= 1'b0;

        // wait for the last results, then a quiet margin
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (sb.faults == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
rtl/core/nps_pkg.sv
rtl/core/nps_ram.sv
rtl/core/nps_pick.sv
rtl/core/nonpreemptive_priority_scheduler.sv
rtl/core/nps_checker.sv
sim/testbench.sv
